@@ rtl/cfa_pkg.sv @@
// Package for the contiguous fit allocator: sizes, codes, item structs and helpers.
// Used by cfa_hole_scan and contiguous_fit_allocator; depends on nothing.
package cfa_pkg;

    // Store geometry.
    localparam int MEM_UNITS  = 1024;
    localparam int OWNER_BITS = 16;
    localparam int ADDR_W     = $clog2(MEM_UNITS);

    // Owner store entry: valid bit on top of the owner id.
    localparam int OWN_W = OWNER_BITS + 1;

    // Fixed field widths of the items.
    localparam int ACTION_W = 2;
    localparam int ID_W     = 16;
    localparam int SIZE_W   = 11;
    localparam int STATUS_W = 3;
    localparam int BASE_W   = 10;
    localparam int MSIZE_W  = 11;
    localparam int POLICY_W = 2;

    // Width for lengths, limits and counters that must hold MEM_UNITS and any request size.
    localparam int LEN_W   = (ADDR_W + 1 > SIZE_W) ? ADDR_W + 1 : SIZE_W;
    localparam int OWN_X_W = (OWNER_BITS > ID_W) ? OWNER_BITS : ID_W;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND    = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_ALLOCATED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REQ_FAILED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REL_FAILED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd5;

    // Fit policy codes.
    localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] FIT_NEXT  = 2'd1;
    localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd2;
    localparam logic [POLICY_W-1:0] FIT_WORST = 2'd3;

    // Configuration register indexes (byte address bit 2).
    localparam logic REG_FIT_POLICY  = 1'b0;
    localparam logic REG_MEMORY_SIZE = 1'b1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ID_W-1:0]     owner_id;
        logic [SIZE_W-1:0]   request_size;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BASE_W-1:0]   base_unit;
        logic [SIZE_W-1:0]   region_size;
    } rsp_item_t;

    // One unit read back during a hole scan.
    typedef struct packed {
        logic              clear;
        logic              vld;
        logic              used;
        logic              last;
        logic [ADDR_W-1:0] idx;
    } hole_ctl_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] base;
    } hole_res_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EVAL,
        S_WRITE,
        S_OWN,
        S_OWN_DRAIN,
        S_DONE
    } state_t;

    // Owner id as stored: exact compare on OWNER_BITS bits.
    function automatic logic [OWNER_BITS-1:0] to_owner(input logic [ID_W-1:0] id);
        logic [OWN_X_W-1:0] t;
        t = OWN_X_W'(id);
        return t[OWNER_BITS-1:0];
    endfunction

    // Unit address as reported in base_unit.
    function automatic logic [BASE_W-1:0] to_base(input logic [ADDR_W-1:0] a);
        logic [LEN_W-1:0] t;
        t = LEN_W'(a);
        return t[BASE_W-1:0];
    endfunction

endpackage

@@ rtl/cfa_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; no package needed.
module cfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/cfa_hole_scan.sv @@
// Hole tracker: follows the free runs seen during a unit scan and keeps the chosen hole.
// Depends on cfa_pkg.
module cfa_hole_scan (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfa_pkg::hole_ctl_t              ctl,
    input  logic [cfa_pkg::POLICY_W-1:0]    policy,
    input  logic [cfa_pkg::LEN_W-1:0]       req_len,
    input  logic [cfa_pkg::LEN_W-1:0]       start_lim,
    output cfa_pkg::hole_res_t              res
);
    import cfa_pkg::*;

    logic              in_run_reg, in_run_next;
    logic [ADDR_W-1:0] run_start_reg, run_start_next;
    logic [LEN_W-1:0]  run_len_reg, run_len_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] best_base_reg, best_base_next;
    logic [LEN_W-1:0]  best_len_reg, best_len_next;

    logic              cand_vld;
    logic [ADDR_W-1:0] cand_start;
    logic [LEN_W-1:0]  cand_len;
    logic              better;

    // Close a run when a used unit or the end of the scan is seen.
    always_comb
    begin
        in_run_next    = in_run_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        cand_vld       = 1'b0;
        cand_start     = run_start_reg;
        cand_len       = run_len_reg;
        if (ctl.vld)
        begin
            if (ctl.used)
            begin
                cand_vld    = in_run_reg;
                in_run_next = 1'b0;
            end
            else
            begin
                run_start_next = in_run_reg ? run_start_reg : ctl.idx;
                run_len_next   = in_run_reg ? run_len_reg + LEN_W'(1) : LEN_W'(1);
                in_run_next    = 1'b1;
                cand_vld       = ctl.last;
                cand_start     = run_start_next;
                cand_len       = run_len_next;
            end
        end
        if (ctl.clear)
        begin
            in_run_next = 1'b0;
        end
    end

    // Policy compare; the strict compares keep the lower hole on a tie.
    always_comb
    begin
        case (policy)
            FIT_BEST:  better = !found_reg || (cand_len < best_len_reg);
            FIT_WORST: better = !found_reg || (cand_len > best_len_reg);
            default:   better = !found_reg;
        endcase
    end

    always_comb
    begin
        found_next     = found_reg;
        best_base_next = best_base_reg;
        best_len_next  = best_len_reg;
        if (cand_vld && (cand_len >= req_len) && (LEN_W'(cand_start) < start_lim) && better)
        begin
            found_next     = 1'b1;
            best_base_next = cand_start;
            best_len_next  = cand_len;
        end
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            in_run_reg <= in_run_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_start_reg <= run_start_next;
        run_len_reg   <= run_len_next;
        best_base_reg <= best_base_next;
        best_len_reg  <= best_len_next;
    end

    assign res.found = found_reg;
    assign res.base  = best_base_reg;

    // A chosen hole always fits the request.
    a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_len_reg >= req_len))
        else $error("chosen hole shorter than request");

    // After the last unit of a scan, a run stays open only when that unit was free.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.vld && ctl.last && !ctl.clear) |=> !in_run_reg || $past(!ctl.used))
        else $error("run left open after last unit");

    // Clearing always drops the previous choice.
    a_clear_drops: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> !found_reg)
        else $error("hole kept across clear");

endmodule

@@ rtl/contiguous_fit_allocator.sv @@
// Top level of the contiguous fit allocator: command sequencer, unit store and APB registers.
// Depends on cfa_pkg, cfa_ram and cfa_hole_scan.
//
// After reset the block sweeps the unit store, one unit a cycle, and takes no item until
// the sweep is done; register writes are taken meanwhile. Each item then runs on the
// single read port of the unit store, one unit a cycle. A request with a zero or too large
// size is refused without a scan; otherwise it scans the units in use (memory_size capped
// at MEM_UNITS), then writes the new region at one unit a cycle; next fit may scan a second
// time from unit zero when nothing fits past the rover. Release and find scan the whole
// store. One item is worked on at a time; a finished result waits in the output register
// while the next item is already taken.
module contiguous_fit_allocator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  cfa_pkg::cmd_item_t cmd,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cfa_pkg::rsp_item_t rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cfa_pkg::*;

    state_t               state_reg, state_next;
    logic [LEN_W-1:0]     cnt_reg, cnt_next;
    logic [LEN_W-1:0]     end_reg, end_next;
    logic [ACTION_W-1:0]  act_reg, act_next;
    logic [OWNER_BITS-1:0] id_reg, id_next;
    logic [SIZE_W-1:0]    req_reg, req_next;
    logic [LEN_W-1:0]     lim_reg, lim_next;
    logic [POLICY_W-1:0]  pol_reg, pol_next;
    logic [ADDR_W-1:0]    r_reg, r_next;
    logic                 pass_b_reg, pass_b_next;
    logic                 p_vld_reg, p_vld_next;
    logic                 p_last_reg, p_last_next;
    logic [ADDR_W-1:0]    p_idx_reg, p_idx_next;
    logic                 hit_reg, hit_next;
    logic [ADDR_W-1:0]    hit_base_reg, hit_base_next;
    logic [SIZE_W-1:0]    hit_size_reg, hit_size_next;
    rsp_item_t            res_reg, res_next;
    rsp_item_t            out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    rover_reg, rover_next;
    logic [POLICY_W-1:0]  fit_policy_reg;
    logic [MSIZE_W-1:0]   mem_size_reg;

    logic                 own_we;
    logic [ADDR_W-1:0]    own_waddr;
    logic [OWN_W-1:0]     own_wdata;
    logic [OWN_W-1:0]     own_rdata;
    logic                 sz_we;
    logic [SIZE_W-1:0]    sz_rdata;
    logic [ADDR_W-1:0]    rd_addr;

    hole_ctl_t            hole_ctl;
    hole_res_t            hole_res;
    logic [LEN_W-1:0]     hole_lim;

    logic [LEN_W-1:0]     cfg_lim;
    logic [LEN_W-1:0]     cmd_req;
    logic [LEN_W-1:0]     new_end;
    logic                 own_match;
    logic                 cfg_wr;

    // Unit store: valid bit and owner per unit, and the region size per unit.
    cfa_ram #(.WIDTH(OWN_W), .DEPTH(MEM_UNITS)) u_owner_ram (
        .clk   (clk),
        .we    (own_we),
        .waddr (own_waddr),
        .wdata (own_wdata),
        .raddr (rd_addr),
        .rdata (own_rdata)
    );

    cfa_ram #(.WIDTH(SIZE_W), .DEPTH(MEM_UNITS)) u_size_ram (
        .clk   (clk),
        .we    (sz_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (req_reg),
        .raddr (rd_addr),
        .rdata (sz_rdata)
    );

    // Hole tracking for request scans.
    assign hole_ctl.clear = (state_reg == S_IDLE) || (state_reg == S_EVAL);
    assign hole_ctl.vld   = p_vld_reg && (act_reg == ACT_REQUEST);
    assign hole_ctl.used  = own_rdata[OWNER_BITS];
    assign hole_ctl.last  = p_last_reg;
    assign hole_ctl.idx   = p_idx_reg;
    assign hole_lim       = pass_b_reg ? LEN_W'(r_reg) : lim_reg;

    cfa_hole_scan u_hole (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (hole_ctl),
        .policy    (pol_reg),
        .req_len   (LEN_W'(req_reg)),
        .start_lim (hole_lim),
        .res       (hole_res)
    );

    // Effective store size and request length for a new item.
    assign cfg_lim = (LEN_W'(mem_size_reg) > LEN_W'(MEM_UNITS)) ? LEN_W'(MEM_UNITS)
                                                                 : LEN_W'(mem_size_reg);
    assign cmd_req = LEN_W'(cmd.request_size);
    assign new_end = LEN_W'(hole_res.base) + LEN_W'(req_reg);

    // A unit read back during a release or find belongs to the owner.
    assign own_match = p_vld_reg && (act_reg != ACT_REQUEST) && own_rdata[OWNER_BITS]
                       && (own_rdata[OWNER_BITS-1:0] == id_reg);

    // Sequencer: next state, datapath and store accesses.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        end_next       = end_reg;
        act_next       = act_reg;
        id_next        = id_reg;
        req_next       = req_reg;
        lim_next       = lim_reg;
        pol_next       = pol_reg;
        r_next         = r_reg;
        pass_b_next    = pass_b_reg;
        p_vld_next     = 1'b0;
        p_last_next    = 1'b0;
        p_idx_next     = cnt_reg[ADDR_W-1:0];
        hit_next       = hit_reg;
        hit_base_next  = hit_base_reg;
        hit_size_next  = hit_size_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        rover_next     = rover_reg;
        own_we         = 1'b0;
        own_waddr      = p_idx_reg;
        own_wdata      = '0;
        sz_we          = 1'b0;
        rd_addr        = cnt_reg[ADDR_W-1:0];

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Owner scan: note the lowest unit and free matching units on release.
        if (own_match)
        begin
            if (!hit_reg)
            begin
                hit_next      = 1'b1;
                hit_base_next = p_idx_reg;
                hit_size_next = sz_rdata;
            end
            if (act_reg == ACT_RELEASE)
            begin
                own_we = 1'b1;
            end
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                own_we    = 1'b1;
                own_waddr = cnt_reg[ADDR_W-1:0];
                cnt_next  = cnt_reg + LEN_W'(1);
                if (cnt_reg == LEN_W'(MEM_UNITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    act_next    = cmd.action;
                    id_next     = to_owner(cmd.owner_id);
                    req_next    = cmd.request_size;
                    lim_next    = cfg_lim;
                    pol_next    = fit_policy_reg;
                    pass_b_next = 1'b0;
                    hit_next    = 1'b0;
                    unique case (cmd.action)
                        ACT_REQUEST:
                        begin
                            if ((cmd_req == '0) || (cmd_req > cfg_lim))
                            begin
                                res_next.status      = ST_REQ_FAILED;
                                res_next.base_unit   = '0;
                                res_next.region_size = cmd.request_size;
                                state_next           = S_DONE;
                            end
                            else
                            begin
                                if ((fit_policy_reg == FIT_NEXT)
                                    && (LEN_W'(rover_reg) < cfg_lim))
                                begin
                                    r_next = rover_reg;
                                end
                                else
                                begin
                                    r_next = '0;
                                end
                                cnt_next   = LEN_W'(r_next);
                                state_next = S_SCAN;
                            end
                        end
                        ACT_RELEASE, ACT_FIND:
                        begin
                            cnt_next   = '0;
                            state_next = S_OWN;
                        end
                        default:
                        begin
                            res_next.status      = ST_NOT_FOUND;
                            res_next.base_unit   = '0;
                            res_next.region_size = '0;
                            state_next           = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                p_vld_next  = 1'b1;
                p_last_next = (cnt_reg == lim_reg - LEN_W'(1));
                cnt_next    = cnt_reg + LEN_W'(1);
                if (p_last_next)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (hole_res.found)
                begin
                    cnt_next   = LEN_W'(hole_res.base);
                    end_next   = new_end;
                    state_next = S_WRITE;
                end
                else if ((pol_reg == FIT_NEXT) && !pass_b_reg && (r_reg != '0))
                begin
                    pass_b_next = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_SCAN;
                end
                else
                begin
                    res_next.status      = ST_REQ_FAILED;
                    res_next.base_unit   = '0;
                    res_next.region_size = req_reg;
                    state_next           = S_DONE;
                end
            end
            S_WRITE:
            begin
                own_we    = 1'b1;
                own_waddr = cnt_reg[ADDR_W-1:0];
                own_wdata = {1'b1, id_reg};
                sz_we     = 1'b1;
                cnt_next  = cnt_reg + LEN_W'(1);
                if (cnt_next == end_reg)
                begin
                    rover_next = (end_reg >= lim_reg) ? '0 : end_reg[ADDR_W-1:0];
                    res_next.status      = ST_ALLOCATED;
                    res_next.base_unit   = to_base(hole_res.base);
                    res_next.region_size = req_reg;
                    state_next           = S_DONE;
                end
            end
            S_OWN:
            begin
                p_vld_next = 1'b1;
                cnt_next   = cnt_reg + LEN_W'(1);
                if (cnt_reg == LEN_W'(MEM_UNITS - 1))
                begin
                    state_next = S_OWN_DRAIN;
                end
            end
            S_OWN_DRAIN:
            begin
                if (hit_next)
                begin
                    res_next.status      = (act_reg == ACT_RELEASE) ? ST_FREED : ST_FOUND;
                    res_next.base_unit   = to_base(hit_base_next);
                    res_next.region_size = hit_size_next;
                end
                else
                begin
                    res_next.status      = (act_reg == ACT_RELEASE) ? ST_REL_FAILED
                                                                    : ST_NOT_FOUND;
                    res_next.base_unit   = '0;
                    res_next.region_size = '0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            p_vld_reg     <= 1'b0;
            pass_b_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            rover_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            p_vld_reg     <= p_vld_next;
            pass_b_reg    <= pass_b_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            rover_reg     <= rover_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg      <= end_next;
        act_reg      <= act_next;
        id_reg       <= id_next;
        req_reg      <= req_next;
        lim_reg      <= lim_next;
        pol_reg      <= pol_next;
        r_reg        <= r_next;
        p_last_reg   <= p_last_next;
        p_idx_reg    <= p_idx_next;
        hit_base_reg <= hit_base_next;
        hit_size_reg <= hit_size_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    // Configuration registers.
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= FIT_FIRST;
            mem_size_reg   <= MSIZE_W'(1024);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_FIT_POLICY:  fit_policy_reg <= pwdata[POLICY_W-1:0];
                REG_MEMORY_SIZE: mem_size_reg   <= pwdata[MSIZE_W-1:0];
                default:         fit_policy_reg <= fit_policy_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FIT_POLICY:  prdata = 32'(fit_policy_reg);
            REG_MEMORY_SIZE: prdata = 32'(mem_size_reg);
            default:         prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Release writes never hit the unit being read in the same cycle.
    a_rmw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OWN) && own_we) |-> (own_waddr != rd_addr))
        else $error("owner store write collides with read");

    // The region write stays inside the units in use.
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> ((cnt_reg < end_reg) && (end_reg <= lim_reg)))
        else $error("region write beyond store limit");

    // No scan data is left in flight once the block is idle.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !p_vld_reg)
        else $error("scan data pending while idle");

    // The size store is written only while placing a region.
    a_size_write: assert property (@(posedge clk) disable iff (!rst_n)
        sz_we |-> (state_reg == S_WRITE))
        else $error("size store written outside placement");

    // A result waiting in the output register is never overwritten.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

endmodule
